// ===== sv/efp_pkg.sv =====
`default_nettype none

package efp_pkg;

	localparam int MaxPayloadDefault = 1500;

	localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

	// One labeled word as it leaves the block.
	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  field_kind;
		logic [10:0] field_index;
		logic        frame_end;
		logic [2:0]  status;
	} result_t;

	// Reflected CRC-32 update by one byte, LSB first.
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/ethernet_frame_parser_fcs_check_core.sv =====
// Ethernet receive deframer with FCS check. Frame bytes enter starting at the first preamble
// byte (frame_start high), and every accepted byte yields exactly one registered labeled word:
// the byte, its field kind, its index within the field, and on the closing byte the frame status.
// A new byte can be taken in every cycle in which in_stall is low; the CRC-32 byte update is done
// in the same cycle as the byte is taken. A two-word output buffer decouples the sides, so
// in_stall rises only when two finished words wait behind a stalled output.
// The payload length comes from given_length when length_known is set at frame start, else
// from a type/length field of at most 1500; the FCS is compared least significant byte first.
`default_nettype none

module ethernet_frame_parser_fcs_check_core #(
	parameter int MAX_PAYLOAD = efp_pkg::MaxPayloadDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_start,
	input  wire logic        length_known,
	input  wire logic [10:0] given_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       byte_out,
	output logic [2:0]       field_kind,
	output logic [10:0]      field_index,
	output logic             frame_end,
	output logic [2:0]       status
);

	typedef enum logic [2:0] {
		PhPre  = 3'd0,
		PhDst  = 3'd1,
		PhSrc  = 3'd2,
		PhTyp  = 3'd3,
		PhPay  = 3'd4,
		PhFcs  = 3'd5,
		PhIdle = 3'd6
	} phase_t;

	localparam logic [2:0]  StProgress = 3'd0;
	localparam logic [2:0]  StGood     = 3'd1;
	localparam logic [2:0]  StBad      = 3'd2;
	localparam logic [2:0]  StNoLength = 3'd3;
	localparam logic [2:0]  StTooLarge = 3'd4;

	localparam logic [10:0] PreLen    = 11'd8;
	localparam logic [10:0] MacLen    = 11'd6;
	localparam logic [10:0] TypLen    = 11'd2;
	localparam logic [10:0] FcsLen    = 11'd4;
	localparam logic [15:0] TypeLimit = 16'd1500;
	localparam logic [10:0] MaxPay    = 11'(MAX_PAYLOAD);

	phase_t      phase_q;
	logic [10:0] cnt_q;
	logic [31:0] crc_q;
	logic [15:0] tl_q;
	logic [10:0] pl_q;
	logic        lm_q;
	logic        fm_q;

	phase_t      ph, ph_d;
	logic [10:0] cnt, cnt_d, cnt_inc;
	logic [31:0] crc, crc_d, crc_x;
	logic [15:0] tl, tl_d;
	logic [10:0] pl, pl_d;
	logic        lm;
	logic        fm, fm_d;
	logic [7:0]  want;
	logic        in_acc;

	efp_pkg::result_t res;
	efp_pkg::result_t out_data;

	assign in_acc = in_valid && !in_stall;

	always_comb begin
		// A frame start overrides whatever frame was open.
		ph  = frame_start ? PhPre : phase_q;
		cnt = frame_start ? 11'd0 : cnt_q;
		crc = frame_start ? efp_pkg::CrcInit : crc_q;
		tl  = frame_start ? 16'd0 : tl_q;
		fm  = frame_start ? 1'b1 : fm_q;
		lm  = frame_start ? length_known : lm_q;
		pl  = frame_start ? given_length : pl_q;

		ph_d    = ph;
		cnt_d   = cnt;
		crc_d   = crc;
		tl_d    = tl;
		fm_d    = fm;
		pl_d    = pl;
		cnt_inc = cnt + 11'd1;
		crc_x   = crc ^ efp_pkg::CrcInit;

		unique case (cnt[1:0])
			2'd0: want = crc_x[7:0];
			2'd1: want = crc_x[15:8];
			2'd2: want = crc_x[23:16];
			2'd3: want = crc_x[31:24];
		endcase

		res.byte_out    = rx_byte;
		res.field_kind  = ph;
		res.field_index = cnt;
		res.frame_end   = 1'b0;
		res.status      = StProgress;

		unique case (ph)
			PhPre: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= PreLen) begin
					ph_d  = PhDst;
					cnt_d = 11'd0;
				end
			end
			PhDst, PhSrc: begin
				crc_d = efp_pkg::crc_byte(crc, rx_byte);
				cnt_d = cnt_inc;
				if (cnt_inc >= MacLen) begin
					ph_d  = (ph == PhDst) ? PhSrc : PhTyp;
					cnt_d = 11'd0;
				end
			end
			PhTyp: begin
				crc_d = efp_pkg::crc_byte(crc, rx_byte);
				tl_d  = {tl[7:0], rx_byte};
				cnt_d = cnt_inc;
				if (cnt_inc >= TypLen) begin
					cnt_d = 11'd0;
					if (lm) begin
						if (pl > MaxPay) begin
							res.frame_end = 1'b1;
							res.status    = StTooLarge;
							ph_d          = PhIdle;
						end
					end else if (tl_d <= TypeLimit) begin
						pl_d = tl_d[10:0];
					end else begin
						res.frame_end = 1'b1;
						res.status    = StNoLength;
						ph_d          = PhIdle;
					end
					if (!res.frame_end) begin
						ph_d = (pl_d == 11'd0) ? PhFcs : PhPay;
					end
				end
			end
			PhPay: begin
				crc_d = efp_pkg::crc_byte(crc, rx_byte);
				cnt_d = cnt_inc;
				if (cnt_inc >= pl) begin
					ph_d  = PhFcs;
					cnt_d = 11'd0;
				end
			end
			PhFcs: begin
				if (want != rx_byte) begin
					fm_d = 1'b0;
				end
				cnt_d = cnt_inc;
				if (cnt_inc >= FcsLen) begin
					res.frame_end = 1'b1;
					res.status    = fm_d ? StGood : StBad;
					ph_d          = PhIdle;
					cnt_d         = 11'd0;
				end
			end
			default: begin
				res.field_kind  = PhIdle;
				res.field_index = 11'd0;
				ph_d            = PhIdle;
				cnt_d           = 11'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
			cnt_q   <= 11'd0;
			crc_q   <= efp_pkg::CrcInit;
			tl_q    <= 16'd0;
			pl_q    <= 11'd0;
			lm_q    <= 1'b0;
			fm_q    <= 1'b1;
		end else if (in_acc) begin
			phase_q <= ph_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			tl_q    <= tl_d;
			pl_q    <= pl_d;
			lm_q    <= lm;
			fm_q    <= fm_d;
		end
	end

	efp_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.out_stall (out_stall)
	);

	assign byte_out    = out_data.byte_out;
	assign field_kind  = out_data.field_kind;
	assign field_index = out_data.field_index;
	assign frame_end   = out_data.frame_end;
	assign status      = out_data.status;

	// A status is reported exactly on the word that closes a frame.
	a_status_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_end == (status != StProgress)))
		else $error("status and frame end disagree");

	// Ignored bytes always carry index zero.
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && field_kind == PhIdle) |-> (field_index == 11'd0))
		else $error("ignored byte with nonzero index");

	// Every way into the ignored phase clears the byte counter.
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PhIdle) |-> (cnt_q == 11'd0))
		else $error("byte counter nonzero while idle");

endmodule

`default_nettype wire

// ===== sv/efp_out_skid.sv =====
`default_nettype none

module efp_out_skid (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire efp_pkg::result_t in_data,
	output logic                  in_stall,
	output logic                  out_valid,
	output efp_pkg::result_t      out_data,
	input  wire logic             out_stall
);

	logic             out_valid_q;
	logic             skid_valid_q;
	efp_pkg::result_t out_data_q;
	efp_pkg::result_t skid_data_q;
	logic             advance;
	logic             in_acc;

	// The output register may load whenever it is empty or being drained.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (advance) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_acc) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The skid word is always older than nothing: the output register is full too.
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held while output register empty");

endmodule

`default_nettype wire
